// ===== hw/rtl/gspf_pkg.sv =====
`default_nettype none
package gspf_pkg;

    localparam int MAX_STOPS_DEF = 8;
    localparam int POS_W         = 32;
    localparam int AXIS_W        = 31;
    localparam int DIV_W         = 48;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 31;

    localparam logic [1:0] UNIT_NONE = 2'd0;
    localparam logic [1:0] UNIT_FRAC = 2'd1;
    localparam logic [1:0] UNIT_LEN  = 2'd2;
    localparam logic [1:0] UNIT_RSVD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_WRAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS = 1'b1;

    localparam logic signed [POS_W-1:0] POS_ONE = 32'sd65536;

    typedef struct packed {
        logic [31:0]        stop_color;
        logic signed [31:0] stop_position;
        logic [1:0]         stop_unit;
        logic               stop_last;
    } stop_t;

    typedef struct packed {
        logic [31:0]        out_color;
        logic signed [31:0] out_position;
        logic               out_last;
        logic               out_overflow;
    } result_t;

    typedef enum logic [2:0] {
        SEL_FIRST,
        SEL_ZERO,
        SEL_ONE,
        SEL_SPAN,
        SEL_END
    } out_sel_t;

    typedef struct packed {
        logic     ld_store;
        logic     ld_div;
        logic     ld_div_wr;
        logic     p1_wr;
        logic     p1_first;
        logic     p1_tail;
        logic     set_begin;
        logic     scan_hit;
        logic     scan_wrap;
        logic     mul;
        logic     span_div;
        logic     end_adv;
        logic     emit;
        out_sel_t sel;
        logic     last;
        logic     overflow;
    } cmd_t;

    typedef struct packed {
        logic conic;
        logic known;
        logic div_done;
    } sts_t;

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [DIV_W:0] v);
        logic signed [DIV_W:0] hi;
        logic signed [DIV_W:0] lo;
        hi = (DIV_W+1)'(64'sh7FFFFFFF);
        lo = -(DIV_W+1)'(64'sh80000000);
        if (v > hi)
            return 32'sh7FFFFFFF;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gradient_stop_position_fixup.sv =====
`default_nettype none
// channel   signals                                   transfer when
// stop in   start, busy, stop                         start && !busy
// result    result_valid, result                      result_valid (one cycle, no stall)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// fraction and unspecified stops, and length stops in conic mode, load back to back
// a length stop in linear mode runs the 48-step serial divider and holds busy meanwhile
// on the last stop: a clamp walk visits each stop in order, then every stop is emitted;
// a spread stop waits for a multiply and the serial divider before its result
// rst_n resets the controller, list count and config; the stores need no clearing
// results cannot be stalled; busy drops in the cycle of the last result
module gradient_stop_position_fixup #(
    parameter int MAX_STOPS = gspf_pkg::MAX_STOPS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire gspf_pkg::stop_t                 stop,
    output logic                                 result_valid,
    output gspf_pkg::result_t                    result,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gspf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gspf_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IW = $clog2(MAX_STOPS);
    localparam int CW = $clog2(MAX_STOPS + 1);

    gspf_pkg::cmd_t  cmd;
    gspf_pkg::sts_t  sts;
    logic [IW-1:0]   addr;
    logic [CW-1:0]   k;
    logic [CW-1:0]   span;

    assign cfg_ready = 1'b1;

    gspf_ctrl #(.MAX_STOPS(MAX_STOPS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .stop_unit (stop.stop_unit),
        .stop_last (stop.stop_last),
        .sts       (sts),
        .cmd       (cmd),
        .addr      (addr),
        .k         (k),
        .span      (span)
    );

    gspf_dp #(.MAX_STOPS(MAX_STOPS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .stop         (stop),
        .cmd          (cmd),
        .addr         (addr),
        .k            (k),
        .span         (span),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.out_last |-> busy)
        else $error("result outside a busy interval");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_last |=> !result_valid)
        else $error("result follows the last one");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_last |-> !busy)
        else $error("still busy after the last result");

endmodule
`default_nettype wire

// ===== hw/rtl/gspf_ram.sv =====
`default_nettype none
module gspf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/gspf_div.sv =====
`default_nettype none
module gspf_div #(
    parameter int DW = gspf_pkg::DIV_W,
    parameter int VW = gspf_pkg::AXIS_W
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [DW-1:0] dividend,
    input  wire logic [VW-1:0]        divisor,
    output logic                      done,
    output logic signed [DW-1:0]      quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              neg_reg,  neg_next;
    logic [VW-1:0]     rem_reg,  rem_next;
    logic [DW-1:0]     quo_reg,  quo_next;
    logic [VW-1:0]     dvs_reg,  dvs_next;
    logic [VW:0]       trial;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        ge        = (trial >= {1'b0, dvs_reg});
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(DW);
            neg_next = dividend[DW-1];
            rem_next = '0;
            quo_next = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = ge ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule
`default_nettype wire

// ===== hw/rtl/gspf_dp.sv =====
`default_nettype none
module gspf_dp #(
    parameter int MAX_STOPS = gspf_pkg::MAX_STOPS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire gspf_pkg::stop_t                       stop,
    input  wire gspf_pkg::cmd_t                        cmd,
    input  wire logic [$clog2(MAX_STOPS)-1:0]          addr,
    input  wire logic [$clog2(MAX_STOPS+1)-1:0]        k,
    input  wire logic [$clog2(MAX_STOPS+1)-1:0]        span,
    output gspf_pkg::sts_t                             sts,
    input  wire logic                                  cfg_valid,
    input  wire logic [gspf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gspf_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                       result_valid,
    output gspf_pkg::result_t                          result
);

    localparam int CW = $clog2(MAX_STOPS + 1);
    localparam int PW = 35 + CW;
    localparam int DW = gspf_pkg::DIV_W;
    localparam int AW = gspf_pkg::AXIS_W;

    logic                       wrap_reg;
    logic [AW-1:0]              axis_reg;
    logic signed [31:0]         a_reg, pos0_reg, prev_reg;
    logic signed [32:0]         anchor_reg;
    logic signed [33:0]         diff_reg;
    logic signed [PW-1:0]       prod_reg;
    logic                       out_valid_reg;
    gspf_pkg::result_t          out_reg;

    logic [31:0]                color_rd;
    logic [32:0]                pos_rd;
    logic                       pos_we;
    logic [32:0]                pos_wd;
    logic signed [31:0]         d;
    logic                       kn, kn2;
    logic signed [31:0]         v, v0;
    logic signed [32:0]         anchor_c;
    logic                       div_start;
    logic signed [DW-1:0]       dvd;
    logic [AW-1:0]              dvs;
    logic                       div_done;
    logic signed [DW-1:0]       q;
    logic signed [31:0]         q_sat, span_pos, pos_sel;
    logic                       in_known;
    logic signed [31:0]         in_pos;

    assign d  = $signed(pos_rd[31:0]);
    assign kn = pos_rd[32];

    always_comb
    begin
        in_known = (stop.stop_unit == gspf_pkg::UNIT_FRAC);
        in_pos   = in_known ? stop.stop_position : 32'sd0;
        kn2      = kn | (cmd.p1_tail & ~wrap_reg);
        v0       = kn ? d : gspf_pkg::POS_ONE;
        if (cmd.p1_first)
            v = kn ? d : 32'sd0;
        else
            v = (v0 < prev_reg) ? prev_reg : v0;
        q_sat    = gspf_pkg::sat32((DW+1)'(q));
        span_pos = gspf_pkg::sat32((DW+1)'(a_reg) + (DW+1)'(q));
        anchor_c = cmd.scan_hit ? 33'(d) : (33'(pos0_reg) + 33'(gspf_pkg::POS_ONE));
        pos_we   = 1'b0;
        pos_wd   = {in_known, in_pos};
        if (cmd.ld_store)
        begin
            pos_we = 1'b1;
        end
        else if (cmd.ld_div_wr)
        begin
            pos_we = 1'b1;
            pos_wd = {1'b1, q_sat};
        end
        else if (cmd.p1_wr && (cmd.p1_first || kn2))
        begin
            pos_we = 1'b1;
            pos_wd = {1'b1, v};
        end
        div_start = cmd.ld_div | cmd.span_div;
        if (cmd.ld_div)
        begin
            dvd = {stop.stop_position, 16'b0};
            dvs = (axis_reg == '0) ? AW'(1) : axis_reg;
        end
        else
        begin
            dvd = {{(DW-PW){prod_reg[PW-1]}}, prod_reg};
            dvs = AW'(span);
        end
        case (cmd.sel)
            gspf_pkg::SEL_FIRST: pos_sel = pos0_reg;
            gspf_pkg::SEL_ZERO:  pos_sel = 32'sd0;
            gspf_pkg::SEL_ONE:   pos_sel = gspf_pkg::POS_ONE;
            gspf_pkg::SEL_SPAN:  pos_sel = span_pos;
            gspf_pkg::SEL_END:   pos_sel = anchor_reg[31:0];
            default:             pos_sel = 32'sd0;
        endcase
    end

    gspf_ram #(.WIDTH(32), .DEPTH(MAX_STOPS)) u_color_ram (
        .clk   (clk),
        .we    (cmd.ld_store),
        .waddr (addr),
        .wdata (stop.stop_color),
        .raddr (addr),
        .rdata (color_rd)
    );

    gspf_ram #(.WIDTH(33), .DEPTH(MAX_STOPS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (addr),
        .wdata (pos_wd),
        .raddr (addr),
        .rdata (pos_rd)
    );

    gspf_div #(.DW(DW), .VW(AW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg      <= 1'b0;
            axis_reg      <= AW'(65536);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit;
            if (cfg_valid)
            begin
                case (cfg_index)
                    gspf_pkg::REG_WRAP: wrap_reg <= cfg_data[0];
                    gspf_pkg::REG_AXIS: axis_reg <= cfg_data;
                    default:            wrap_reg <= wrap_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.p1_wr)
        begin
            if (cmd.p1_first)
            begin
                pos0_reg <= v;
                prev_reg <= v;
            end
            else if (kn2)
            begin
                prev_reg <= v;
            end
        end
        if (cmd.set_begin)
            a_reg <= pos0_reg;
        else if (cmd.end_adv)
            a_reg <= anchor_reg[31:0];
        if (cmd.scan_hit || cmd.scan_wrap)
        begin
            anchor_reg <= anchor_c;
            diff_reg   <= 34'(anchor_c) - 34'(a_reg);
        end
        if (cmd.mul)
            prod_reg <= PW'(diff_reg * $signed({1'b0, k}));
        if (cmd.emit)
        begin
            out_reg.out_color    <= color_rd;
            out_reg.out_position <= pos_sel;
            out_reg.out_last     <= cmd.last;
            out_reg.out_overflow <= cmd.overflow;
        end
    end

    assign sts.conic    = wrap_reg;
    assign sts.known    = kn;
    assign sts.div_done = div_done;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/gspf_ctrl.sv =====
`default_nettype none
module gspf_ctrl #(
    parameter int MAX_STOPS = gspf_pkg::MAX_STOPS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         stop_unit,
    input  wire logic                               stop_last,
    input  wire gspf_pkg::sts_t                     sts,
    output gspf_pkg::cmd_t                          cmd,
    output logic [$clog2(MAX_STOPS)-1:0]            addr,
    output logic [$clog2(MAX_STOPS+1)-1:0]          k,
    output logic [$clog2(MAX_STOPS+1)-1:0]          span
);

    localparam int IW = $clog2(MAX_STOPS);
    localparam int CW = $clog2(MAX_STOPS + 1);

    typedef enum logic [3:0] {
        IDLE, LD_WAIT, P1_RD, P1_WR, E0_RD, E0_EM, SGL_EM, NEXT,
        SC_RD, SC_CHK, SP_MUL, SP_DIV, SP_WAIT, SP_EM, END_RD, END_EM
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  loaded_reg, loaded_next;
    logic           ovf_reg, ovf_next;
    logic           hold_reg, hold_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  begin_reg, begin_next;
    logic [CW-1:0]  end_reg, end_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  span_reg, span_next;
    logic           busy_reg, busy_next;
    logic [CW-1:0]  addr_c;
    logic [CW-1:0]  cur;
    logic [CW-1:0]  cnt_m1;

    always_comb
    begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        ovf_next    = ovf_reg;
        hold_next   = hold_reg;
        i_next      = i_reg;
        begin_next  = begin_reg;
        end_next    = end_reg;
        k_next      = k_reg;
        span_next   = span_reg;
        cmd         = '0;
        cmd.sel     = gspf_pkg::SEL_FIRST;
        cmd.overflow = ovf_reg;
        addr_c      = i_reg;
        cur         = begin_reg + k_reg;
        cnt_m1      = loaded_reg - CW'(1);
        case (state_reg)
            IDLE:
            begin
                addr_c = loaded_reg;
                if (start)
                begin
                    i_next = '0;
                    if (loaded_reg < CW'(MAX_STOPS))
                    begin
                        cmd.ld_store = 1'b1;
                        loaded_next  = loaded_reg + CW'(1);
                        if (stop_unit == gspf_pkg::UNIT_LEN && !sts.conic)
                        begin
                            cmd.ld_div = 1'b1;
                            hold_next  = stop_last;
                            state_next = LD_WAIT;
                        end
                        else if (stop_last)
                        begin
                            state_next = P1_RD;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        if (stop_last)
                            state_next = P1_RD;
                    end
                end
            end
            LD_WAIT:
            begin
                addr_c = cnt_m1;
                if (sts.div_done)
                begin
                    cmd.ld_div_wr = 1'b1;
                    state_next    = hold_reg ? P1_RD : IDLE;
                end
            end
            P1_RD:
            begin
                state_next = P1_WR;
            end
            P1_WR:
            begin
                cmd.p1_wr    = 1'b1;
                cmd.p1_first = (i_reg == '0);
                cmd.p1_tail  = (i_reg == cnt_m1);
                if (i_reg == cnt_m1)
                    state_next = E0_RD;
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = P1_RD;
                end
            end
            E0_RD:
            begin
                addr_c     = '0;
                state_next = E0_EM;
            end
            E0_EM:
            begin
                addr_c   = '0;
                cmd.emit = 1'b1;
                if (loaded_reg == CW'(1))
                begin
                    if (sts.conic)
                    begin
                        cmd.last   = 1'b1;
                        state_next = IDLE;
                        loaded_next = '0;
                        ovf_next    = 1'b0;
                    end
                    else
                    begin
                        cmd.sel    = gspf_pkg::SEL_ZERO;
                        state_next = SGL_EM;
                    end
                end
                else
                begin
                    cmd.set_begin = 1'b1;
                    begin_next    = '0;
                    state_next    = NEXT;
                end
            end
            SGL_EM:
            begin
                addr_c      = '0;
                cmd.emit    = 1'b1;
                cmd.sel     = gspf_pkg::SEL_ONE;
                cmd.last    = 1'b1;
                loaded_next = '0;
                ovf_next    = 1'b0;
                state_next  = IDLE;
            end
            NEXT:
            begin
                if (begin_reg == cnt_m1)
                begin
                    loaded_next = '0;
                    ovf_next    = 1'b0;
                    state_next  = IDLE;
                end
                else
                begin
                    i_next     = begin_reg + CW'(1);
                    state_next = SC_RD;
                end
            end
            SC_RD:
            begin
                state_next = SC_CHK;
            end
            SC_CHK:
            begin
                k_next = CW'(1);
                if (sts.known)
                begin
                    cmd.scan_hit = 1'b1;
                    end_next     = i_reg;
                    span_next    = i_reg - begin_reg;
                    state_next   = ((i_reg - begin_reg) > CW'(1)) ? SP_MUL : END_RD;
                end
                else if (i_reg == cnt_m1)
                begin
                    cmd.scan_wrap = 1'b1;
                    end_next      = loaded_reg;
                    span_next     = loaded_reg - begin_reg;
                    state_next    = SP_MUL;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = SC_RD;
                end
            end
            SP_MUL:
            begin
                addr_c     = cur;
                cmd.mul    = 1'b1;
                state_next = SP_DIV;
            end
            SP_DIV:
            begin
                addr_c       = cur;
                cmd.span_div = 1'b1;
                state_next   = SP_WAIT;
            end
            SP_WAIT:
            begin
                addr_c = cur;
                if (sts.div_done)
                    state_next = SP_EM;
            end
            SP_EM:
            begin
                addr_c   = cur;
                cmd.emit = 1'b1;
                cmd.sel  = gspf_pkg::SEL_SPAN;
                cmd.last = (cur == cnt_m1);
                k_next   = k_reg + CW'(1);
                if ((k_reg + CW'(1)) < span_reg)
                    state_next = SP_MUL;
                else if (end_reg < loaded_reg)
                    state_next = END_RD;
                else
                begin
                    loaded_next = '0;
                    ovf_next    = 1'b0;
                    state_next  = IDLE;
                end
            end
            END_RD:
            begin
                addr_c     = end_reg;
                state_next = END_EM;
            end
            END_EM:
            begin
                addr_c      = end_reg;
                cmd.emit    = 1'b1;
                cmd.sel     = gspf_pkg::SEL_END;
                cmd.last    = (end_reg == cnt_m1);
                cmd.end_adv = 1'b1;
                begin_next  = end_reg;
                if (end_reg == cnt_m1)
                begin
                    loaded_next = '0;
                    ovf_next    = 1'b0;
                    state_next  = IDLE;
                end
                else
                    state_next = NEXT;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
        busy_next = (state_next != IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            loaded_reg <= '0;
            ovf_reg    <= 1'b0;
            hold_reg   <= 1'b0;
            i_reg      <= '0;
            begin_reg  <= '0;
            end_reg    <= '0;
            k_reg      <= '0;
            span_reg   <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            ovf_reg    <= ovf_next;
            hold_reg   <= hold_next;
            i_reg      <= i_next;
            begin_reg  <= begin_next;
            end_reg    <= end_next;
            k_reg      <= k_next;
            span_reg   <= span_next;
            busy_reg   <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign addr = addr_c[IW-1:0];
    assign k    = k_reg;
    assign span = span_reg;

endmodule
`default_nettype wire
